// ===== hdl/dsa_pkg.sv =====
`default_nettype none
package dsa_pkg;

    localparam int SLOTS    = 64;
    localparam int RESERVED = 3;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);

    localparam int FUNC_W   = 2;
    localparam int SLOTIN_W = 7;
    localparam int KIND_W   = 4;
    localparam int HANDLE_W = 64;
    localparam int AUX_W    = 32;
    localparam int SLOTO_W  = 6;
    localparam int STAT_W   = 2;
    localparam int LIVE_W   = 6;

    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_GET   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SLOTIN_W-1:0] slot;
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [AUX_W-1:0]    aux;
    } t_req;

    typedef struct packed {
        logic                wr_en;
        logic [SLOT_W-1:0]   wr_idx;
        logic [SLOT_W-1:0]   rd_idx;
        logic                hit;
        logic [STAT_W-1:0]   status;
        logic [SLOTO_W-1:0]  slot_out;
        logic [LIVE_W-1:0]   live_count;
    } t_dec;

endpackage
`default_nettype wire

// ===== hdl/dsa_table.sv =====
`default_nettype none
module dsa_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [dsa_pkg::SLOT_W-1:0]    i_wr_idx,
    input  wire logic [dsa_pkg::KIND_W-1:0]    i_wr_kind,
    input  wire logic [dsa_pkg::HANDLE_W-1:0]  i_wr_handle,
    input  wire logic [dsa_pkg::AUX_W-1:0]     i_wr_aux,
    input  wire logic                          i_rd_en,
    input  wire logic [dsa_pkg::SLOT_W-1:0]    i_rd_idx,
    output logic      [dsa_pkg::KIND_W-1:0]    o_rd_kind,
    output logic      [dsa_pkg::HANDLE_W-1:0]  o_rd_handle,
    output logic      [dsa_pkg::AUX_W-1:0]     o_rd_aux
);

    logic [dsa_pkg::KIND_W-1:0]   r_kind_mem   [dsa_pkg::SLOTS];
    logic [dsa_pkg::HANDLE_W-1:0] r_handle_mem [dsa_pkg::SLOTS];
    logic [dsa_pkg::AUX_W-1:0]    r_aux_mem    [dsa_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_kind_mem[i_wr_idx]   <= i_wr_kind;
            r_handle_mem[i_wr_idx] <= i_wr_handle;
            r_aux_mem[i_wr_idx]    <= i_wr_aux;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_kind   <= r_kind_mem[i_rd_idx];
            o_rd_handle <= r_handle_mem[i_rd_idx];
            o_rd_aux    <= r_aux_mem[i_rd_idx];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/dsa_alloc.sv =====
`default_nettype none
module dsa_alloc (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire dsa_pkg::t_req i_req,
    output dsa_pkg::t_dec      o_dec
);

    logic [dsa_pkg::SLOTS-1:0] r_used;
    logic [dsa_pkg::SLOTS-1:0] n_used;
    logic [dsa_pkg::CNT_W-1:0] r_count;
    logic [dsa_pkg::CNT_W-1:0] n_count;

    logic                       found;
    logic [dsa_pkg::SLOT_W-1:0] pick;
    logic [dsa_pkg::SLOT_W-1:0] idx;
    logic                       live;

    // lowest free slot above the reserved range
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = dsa_pkg::SLOTS - 1; i >= dsa_pkg::RESERVED; i--) begin
            if (!r_used[i]) begin
                found = 1'b1;
                pick  = dsa_pkg::SLOT_W'(i);
            end
        end
    end

    assign idx  = dsa_pkg::SLOT_W'(i_req.slot);
    assign live = (32'(i_req.slot) < 32'(dsa_pkg::SLOTS))
               && (32'(i_req.slot) >= 32'(dsa_pkg::RESERVED))
               && r_used[idx];

    always_comb begin
        n_used         = r_used;
        n_count        = r_count;
        o_dec.wr_en    = 1'b0;
        o_dec.wr_idx   = pick;
        o_dec.rd_idx   = idx;
        o_dec.hit      = 1'b0;
        o_dec.status   = dsa_pkg::ST_MISS;
        o_dec.slot_out = dsa_pkg::SLOTO_W'(i_req.slot);
        case (i_req.func)
            dsa_pkg::FN_ALLOC: begin
                if (found) begin
                    o_dec.wr_en    = i_fire;
                    o_dec.status   = dsa_pkg::ST_OK;
                    o_dec.slot_out = dsa_pkg::SLOTO_W'(pick);
                    if (i_req.kind != '0) begin
                        n_used[pick] = 1'b1;
                        n_count      = r_count + 1'b1;
                    end
                end else begin
                    o_dec.status   = dsa_pkg::ST_FULL;
                    o_dec.slot_out = '0;
                end
            end
            dsa_pkg::FN_GET: begin
                if (live) begin
                    o_dec.hit    = 1'b1;
                    o_dec.status = dsa_pkg::ST_OK;
                end
            end
            dsa_pkg::FN_FREE: begin
                if (live) begin
                    o_dec.status = dsa_pkg::ST_OK;
                    n_used[idx]  = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        o_dec.live_count = dsa_pkg::LIVE_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/descriptor_slot_allocator.sv =====
// Descriptor slot allocator: a 64-slot table whose lowest 3 slots are reserved.
// A request word carries alloc, get or free; alloc takes the lowest free slot
// above the reserved range. One request is accepted per cycle while the result
// is not stalled; its result word passes through the request register, where
// the free-slot bitmap is priority encoded and the table is written or read,
// and then the result register fed by the registered table read.
// A stalled result holds and one further request is buffered behind it.
// Slots read as free after reset; no clearing pass is needed.
`default_nettype none
module descriptor_slot_allocator (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // slot[6:0], kind[10:7], handle[74:11], aux_word[106:75], zero pad[111:107]
    input  wire logic [111:0] i_s_tdata,
    // func[1:0]
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // slot_out[5:0], kind_out[9:6], handle_out[73:10], aux_out[105:74],
    // live_count[111:106]
    output logic      [111:0] o_m_tdata,
    // status[1:0]
    output logic      [1:0]   o_m_tuser
);

    dsa_pkg::t_req r_req;
    logic          r_req_valid;
    dsa_pkg::t_dec dec;
    dsa_pkg::t_dec r_res;
    logic          r_m_valid;
    logic          adv;
    logic          fire;
    logic          acc;

    logic [dsa_pkg::KIND_W-1:0]   rd_kind;
    logic [dsa_pkg::HANDLE_W-1:0] rd_handle;
    logic [dsa_pkg::AUX_W-1:0]    rd_aux;

    assign adv        = !r_m_valid || i_m_tready;
    assign fire       = r_req_valid && adv;
    assign o_s_tready = !r_req_valid || adv;
    assign acc        = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (acc) begin
            r_req_valid <= 1'b1;
        end else if (adv) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req.func   <= i_s_tuser;
            r_req.slot   <= i_s_tdata[6:0];
            r_req.kind   <= i_s_tdata[10:7];
            r_req.handle <= i_s_tdata[74:11];
            r_req.aux    <= i_s_tdata[106:75];
        end
    end

    dsa_alloc u_alloc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_req),
        .o_dec   (dec)
    );

    dsa_table u_table (
        .i_clk       (i_clk),
        .i_wr_en     (dec.wr_en),
        .i_wr_idx    (dec.wr_idx),
        .i_wr_kind   (r_req.kind),
        .i_wr_handle (r_req.handle),
        .i_wr_aux    (r_req.aux),
        .i_rd_en     (fire),
        .i_rd_idx    (dec.rd_idx),
        .o_rd_kind   (rd_kind),
        .o_rd_handle (rd_handle),
        .o_rd_aux    (rd_aux)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (fire) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= dec;
        end
    end

    assign o_m_tvalid         = r_m_valid;
    assign o_m_tuser          = r_res.status;
    assign o_m_tdata[5:0]     = r_res.slot_out;
    assign o_m_tdata[9:6]     = r_res.hit ? rd_kind : '0;
    assign o_m_tdata[73:10]   = r_res.hit ? rd_handle : '0;
    assign o_m_tdata[105:74]  = r_res.hit ? rd_aux : '0;
    assign o_m_tdata[111:106] = r_res.live_count;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dsa_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int DATA_W      = 112;

    // func code with no meaning; the block answers it as a miss
    localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;

    typedef struct packed {
        logic [SLOTO_W-1:0]  slot_out;
        logic [STAT_W-1:0]   status;
        logic [KIND_W-1:0]   kind_out;
        logic [HANDLE_W-1:0] handle_out;
        logic [AUX_W-1:0]    aux_out;
        logic [LIVE_W-1:0]   live_count;
    } t_reply;

    class slot_table_checker;
        logic [KIND_W-1:0]   kind_tab   [SLOTS];
        logic [HANDLE_W-1:0] handle_tab [SLOTS];
        logic [AUX_W-1:0]    aux_tab    [SLOTS];
        int unsigned         live_slots;
        t_reply              replies_due[$];
        int unsigned         errors;
        int unsigned         n_requests, n_placed, n_full, n_get_hit, n_freed, n_miss;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                kind_tab[i]   = '0;
                handle_tab[i] = '0;
                aux_tab[i]    = '0;
            end
            live_slots = 0;
            errors     = 0;
            n_requests = 0;
            n_placed   = 0;
            n_full     = 0;
            n_get_hit  = 0;
            n_freed    = 0;
            n_miss     = 0;
        endfunction

        function bit is_live(int s);
            return s >= RESERVED && s < SLOTS && kind_tab[s] != '0;
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [SLOTIN_W-1:0] slot,
                                   logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle,
                                   logic [AUX_W-1:0] aux);
            t_reply r;
            int     pick;
            int     s;
            s            = int'(slot);
            r.slot_out   = slot[SLOTO_W-1:0];
            r.status     = ST_MISS;
            r.kind_out   = '0;
            r.handle_out = '0;
            r.aux_out    = '0;
            n_requests++;
            case (func)
                FN_ALLOC: begin
                    pick = -1;
                    for (int i = RESERVED; i < SLOTS; i++)
                        if (pick < 0 && kind_tab[i] == '0) pick = i;
                    if (pick >= 0) begin
                        kind_tab[pick]   = kind;
                        handle_tab[pick] = handle;
                        aux_tab[pick]    = aux;
                        if (kind != '0) live_slots++;
                        r.slot_out = pick[SLOTO_W-1:0];
                        r.status   = ST_OK;
                        n_placed++;
                    end else begin
                        r.slot_out = '0;
                        r.status   = ST_FULL;
                        n_full++;
                    end
                end
                FN_GET: begin
                    if (is_live(s)) begin
                        r.status     = ST_OK;
                        r.kind_out   = kind_tab[s];
                        r.handle_out = handle_tab[s];
                        r.aux_out    = aux_tab[s];
                        n_get_hit++;
                    end
                end
                FN_FREE: begin
                    if (is_live(s)) begin
                        kind_tab[s]   = '0;
                        handle_tab[s] = '0;
                        aux_tab[s]    = '0;
                        if (live_slots > 0) live_slots--;
                        r.status = ST_OK;
                        n_freed++;
                    end
                end
                default: ;
            endcase
            if (r.status == ST_MISS) n_miss++;
            r.live_count = live_slots[LIVE_W-1:0];
            replies_due.push_back(r);
        endfunction

        task report(string what, logic [HANDLE_W-1:0] want, logic [HANDLE_W-1:0] got);
            $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
            errors++;
        endtask

        task check_reply(logic [DATA_W-1:0] data, logic [STAT_W-1:0] user);
            t_reply e;
            if (replies_due.size() == 0) begin
                report("reply word with none due", '0, data[63:0]);
                return;
            end
            e = replies_due.pop_front();
            if (data[5:0] !== e.slot_out)
                report("slot_out", HANDLE_W'(e.slot_out), HANDLE_W'(data[5:0]));
            if (user !== e.status)
                report("status", HANDLE_W'(e.status), HANDLE_W'(user));
            if (data[9:6] !== e.kind_out)
                report("kind_out", HANDLE_W'(e.kind_out), HANDLE_W'(data[9:6]));
            if (data[73:10] !== e.handle_out)
                report("handle_out", e.handle_out, data[73:10]);
            if (data[105:74] !== e.aux_out)
                report("aux_out", HANDLE_W'(e.aux_out), HANDLE_W'(data[105:74]));
            if (data[111:106] !== e.live_count)
                report("live_count", HANDLE_W'(e.live_count), HANDLE_W'(data[111:106]));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [DATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]  s_tuser = '0;
    logic               m_tready = 1'b0;
    wire                s_tready;
    wire                m_tvalid;
    wire [DATA_W-1:0]   m_tdata;
    wire [STAT_W-1:0]   m_tuser;

    slot_table_checker  table_sb;
    bit                 hold_off_req = 1'b0;
    int unsigned        n_hold_offs = 0;
    int                 stall_mode = 0;
    int                 mode_left = 0;
    int unsigned        rx_tick = 0;
    int unsigned        idle_cycles = 0;
    int                 burst_left = 0;
    bit                 use_gaps = 1'b1;

    always #5 clk = ~clk;

    descriptor_slot_allocator u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) table_sb.check_reply(m_tdata, m_tuser);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver stall pattern, plus a long hold-off on request
    always begin
        @(negedge clk);
        rx_tick++;
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            n_hold_offs++;
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 64);
            end
            mode_left--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) < 7);
                2:       m_tready <= (rx_tick % 4 == 0);
                default: m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    task automatic send_request(logic [FUNC_W-1:0] func, logic [SLOTIN_W-1:0] slot,
                                logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle,
                                logic [AUX_W-1:0] aux);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, aux, handle, kind, slot};
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        table_sb.note_request(func, slot, kind, handle, aux);
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic wait_all_replies();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (table_sb.replies_due.size() != 0) @(posedge clk);
    endtask

    // mostly a live slot, sometimes reserved or anything in range of the field
    function automatic logic [SLOTIN_W-1:0] choose_slot();
        int start;
        int pick;
        start = $urandom_range(RESERVED, SLOTS - 1);
        pick  = start;
        case ($urandom_range(0, 9))
            0: pick = $urandom_range(0, 127);
            1: pick = $urandom_range(0, RESERVED - 1);
            default: begin
                for (int k = SLOTS - 1; k >= 0; k--)
                    if (table_sb.is_live((start + k) % SLOTS)) pick = (start + k) % SLOTS;
            end
        endcase
        return pick[SLOTIN_W-1:0];
    endfunction

    task automatic random_request(int alloc_pct, int free_pct);
        int                  roll;
        logic [FUNC_W-1:0]   func;
        logic [SLOTIN_W-1:0] slot;
        roll = $urandom_range(0, 99);
        slot = choose_slot();
        if (roll < alloc_pct) begin
            func = FN_ALLOC;
            slot = SLOTIN_W'($urandom_range(0, 127));
        end else if (roll < alloc_pct + free_pct) begin
            func = FN_FREE;
        end else if (roll < 98) begin
            func = FN_GET;
        end else begin
            func = FN_NONE;
            slot = SLOTIN_W'($urandom_range(0, 127));
        end
        send_request(func, slot, KIND_W'($urandom_range(0, 15)), {$urandom, $urandom},
                     $urandom);
    endtask

    initial begin
        table_sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        send_request(FN_GET,   7'd0,   4'd0,  64'd0, 32'd0);
        send_request(FN_FREE,  7'd2,   4'd0,  64'd0, 32'd0);
        send_request(FN_GET,   7'd64,  4'd0,  64'd0, 32'd0);
        send_request(FN_FREE,  7'd127, 4'd0,  64'd0, 32'd0);
        send_request(FN_ALLOC, 7'd127, 4'd15, '1,    32'h7fff_ffff);
        send_request(FN_ALLOC, 7'd0,   4'd1,  64'd0, 32'h8000_0000);
        send_request(FN_GET,   7'd3,   4'd0,  64'd0, 32'd0);
        send_request(FN_GET,   7'd4,   4'd0,  64'd0, 32'd0);
        send_request(FN_ALLOC, 7'd9,   4'd0,  64'h0123_4567_89ab_cdef, 32'hdead_beef);
        send_request(FN_GET,   7'd5,   4'd0,  64'd0, 32'd0);
        send_request(FN_ALLOC, 7'd0,   4'd7,  64'hfedc_ba98_7654_3210, 32'h1234_5678);
        send_request(FN_GET,   7'd5,   4'd0,  64'd0, 32'd0);
        send_request(FN_FREE,  7'd4,   4'd0,  64'd0, 32'd0);
        send_request(FN_FREE,  7'd4,   4'd0,  64'd0, 32'd0);
        send_request(FN_GET,   7'd4,   4'd0,  64'd0, 32'd0);
        send_request(FN_ALLOC, 7'd0,   4'd8,  64'h5555_aaaa_5555_aaaa, 32'hffff_ffff);
        send_request(FN_NONE,  7'd127, 4'd15, '1,    '1);
        send_request(FN_NONE,  7'd3,   4'd0,  64'd0, 32'd0);
        send_request(FN_GET,   7'd63,  4'd0,  64'd0, 32'd0);
        send_request(FN_GET,   7'd67,  4'd0,  64'd0, 32'd0);
        send_request(FN_ALLOC, 7'd0,   4'd15, 64'd0, 32'hffff_ffff);
        send_request(FN_GET,   7'd4,   4'd0,  64'd0, 32'd0);

        // alternate fill and drain phases so the table runs full and empties
        for (int phase = 0; phase < 6; phase++) begin
            use_gaps = (phase != 2);
            if (phase == 1 || phase == 4) hold_off_req = 1'b1;
            if (phase == 3) wait_all_replies();
            for (int n = 0; n < (phase % 2 == 0 ? 110 : 120); n++) begin
                if (use_gaps && burst_left == 0) begin
                    idle_sender($urandom_range(0, 6));
                    burst_left = $urandom_range(1, 24);
                end
                if (burst_left > 0) burst_left--;
                if (phase % 2 == 0) begin
                    random_request(80, 6);
                end else begin
                    random_request(15, 55);
                end
            end
        end

        wait_all_replies();
        repeat (10) @(posedge clk);
        $display("%0d requests: %0d placed, %0d table full, %0d gets hit, %0d freed, %0d misses",
                 table_sb.n_requests, table_sb.n_placed, table_sb.n_full,
                 table_sb.n_get_hit, table_sb.n_freed, table_sb.n_miss);
        $display("receiver long hold-offs: %0d, mismatches: %0d", n_hold_offs, table_sb.errors);
        if (table_sb.errors == 0 && table_sb.replies_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dsa_pkg.sv
hdl/dsa_table.sv
hdl/dsa_alloc.sv
hdl/descriptor_slot_allocator.sv
tb/sv/testbench.sv
